>>> src/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define JLEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that must hold at every edge, reset included.
`define JLEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/jlec_pkg.sv
// Shared types and constants of the jitter LFSR entropy conditioner.
// No dependencies.
`default_nettype none

package jlec_pkg;

    localparam int TICK_W   = 64;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int IN_W     = 64;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [7:0]        rand_byte_t;
    typedef logic [7:0]        count_t;
    typedef logic [2:0]        bit_pos_t;

    // Register indexes, selected by paddr[2].
    localparam logic REG_DIFFS_PER_BIT = 1'b0;

    localparam count_t DIFFS_RESET = 8'd128;

    // Galois feedback mask: top bit plus the low tap pattern.
    localparam tick_t FEEDBACK = {1'b1, {(TICK_W-1){1'b0}}} | tick_t'(12'h175);

    // Result of folding one sample.
    typedef struct packed {
        logic       emit;
        rand_byte_t data;
    } fold_res_t;

endpackage

`default_nettype wire

>>> src/jlec_regs.sv
// APB configuration register block of the entropy conditioner.
// Depends on jlec_pkg.
`default_nettype none

module jlec_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [jlec_pkg::PADDR_W-1:0] paddr,
    input  wire logic [jlec_pkg::PDATA_W-1:0] pwdata,
    output logic      [jlec_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output jlec_pkg::count_t                  diffs_per_bit
);
    import jlec_pkg::*;

    count_t diffs_reg;
    count_t diffs_next;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DIFFS_PER_BIT);

    always_comb
    begin
        diffs_next = diffs_reg;
        if (wr_en)
        begin
            diffs_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diffs_reg <= DIFFS_RESET;
        end
        else
        begin
            diffs_reg <= diffs_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_DIFFS_PER_BIT)
        begin
            prdata = {{(PDATA_W-8){1'b0}}, diffs_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign diffs_per_bit = diffs_reg;

endmodule

`default_nettype wire

>>> src/jlec_fold.sv
// Conditioning state and combinational fold of one counter sample into the LFSR.
// Depends on jlec_pkg.
`default_nettype none

module jlec_fold (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  jlec_pkg::tick_t        ts,
    input  jlec_pkg::count_t       diffs_per_bit,
    output jlec_pkg::fold_res_t    res
);
    import jlec_pkg::*;

    tick_t      lfsr_reg,     lfsr_next;
    tick_t      last_reg,     last_next;
    count_t     count_reg,    count_next;
    bit_pos_t   pos_reg,      pos_next;
    rand_byte_t bits_reg,     bits_next;
    logic       baseline_reg, baseline_next;

    tick_t      mixed;
    tick_t      folded;
    count_t     count_inc;
    rand_byte_t bits_acc;

    always_comb
    begin
        mixed     = lfsr_reg ^ (ts - last_reg);
        folded    = (mixed >> 1) ^ (mixed[0] ? FEEDBACK : '0);
        count_inc = count_reg + 8'd1;
        bits_acc  = bits_reg | (rand_byte_t'(^folded) << pos_reg);

        lfsr_next     = lfsr_reg;
        last_next     = last_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        bits_next     = bits_reg;
        baseline_next = baseline_reg;
        res.emit      = 1'b0;
        res.data      = bits_acc;

        // Repeated samples leave the state untouched.
        if (step && (ts != last_reg))
        begin
            last_next = ts;
            if (baseline_reg)
            begin
                baseline_next = 1'b0;
            end
            else
            begin
                lfsr_next  = folded;
                count_next = count_inc;
                if (count_inc == diffs_per_bit)
                begin
                    count_next = '0;
                    pos_next   = pos_reg + 3'd1;
                    bits_next  = bits_acc;
                    if (pos_reg == 3'd7)
                    begin
                        res.emit      = 1'b1;
                        bits_next     = '0;
                        baseline_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg     <= '0;
            last_reg     <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            bits_reg     <= '0;
            baseline_reg <= 1'b1;
        end
        else
        begin
            lfsr_reg     <= lfsr_next;
            last_reg     <= last_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            bits_reg     <= bits_next;
            baseline_reg <= baseline_next;
        end
    end

endmodule

`default_nettype wire

>>> src/jitter_lfsr_entropy_conditioner_top.sv
// Top level of the jitter LFSR entropy conditioner: input register, fold, output register.
// Depends on jlec_pkg, jlec_regs and jlec_fold.
`default_nettype none

// The block takes one counter sample per clock and folds each difference between
// consecutive distinct samples into a 64-bit Galois LFSR; after diffs_per_bit
// differences the LFSR parity forms one output bit, and eight bits make a byte.
// A sample is registered on acceptance and folded once the output slot is empty
// or being emptied; the byte it completes is then held in the output register.
// Throughput is one sample per cycle, set by the combinational fold (subtract,
// XOR, shift and parity) between the input and output registers; the input
// stalls only while a finished byte waits for out_ready. A byte needs at least
// nine distinct samples: one baseline and eight times diffs_per_bit differences
// (zero in diffs_per_bit means 256). Write diffs_per_bit only while idle.

module jitter_lfsr_entropy_conditioner_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [jlec_pkg::IN_W-1:0]    timestamp,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        random_byte,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [jlec_pkg::PADDR_W-1:0] paddr,
    input  wire logic [jlec_pkg::PDATA_W-1:0] pwdata,
    output logic      [jlec_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);
    import jlec_pkg::*;

    logic       in_valid_reg, in_valid_next;
    tick_t      ts_reg,       ts_next;
    logic       out_valid_reg, out_valid_next;
    rand_byte_t out_data_reg,  out_data_next;

    logic       advance;
    logic       step;
    count_t     diffs_per_bit;
    fold_res_t  res;

    jlec_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .diffs_per_bit (diffs_per_bit)
    );

    jlec_fold u_fold (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .ts            (ts_reg),
        .diffs_per_bit (diffs_per_bit),
        .res           (res)
    );

    // The fold may run whenever the output slot is empty or being emptied.
    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        ts_next        = ts_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (advance)
        begin
            in_valid_next  = 1'b0;
            out_valid_next = step && res.emit;
            if (step && res.emit)
            begin
                out_data_next = res.data;
            end
        end
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            ts_next       = timestamp[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg       <= ts_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign random_byte = out_data_reg;

endmodule

`default_nettype wire

>>> src/jlec_check.sv
// Port-level checker for the entropy conditioner top level, with its bind.
// Depends on assert_macros.svh and jlec_pkg.
`default_nettype none
`include "assert_macros.svh"

module jlec_check (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [7:0]                   random_byte,
    input wire logic                         pready
);
    import jlec_pkg::*;

    // A stalled byte must hold its value.
    `JLEC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(random_byte), "random_byte changed while stalled")

    // Bytes are at least nine samples apart, so none can follow a transaction directly.
    `JLEC_ASSERT(a_out_gap, clk, rst_n, out_valid && out_ready |=> !out_valid, "two bytes in consecutive cycles")

    // The input side stalls only behind a blocked output byte.
    `JLEC_ASSERT(a_in_stall, clk, rst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

    // The configuration port never inserts wait states.
    `JLEC_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")

endmodule

bind jitter_lfsr_entropy_conditioner_top jlec_check u_jlec_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_byte (random_byte),
    .pready      (pready)
);

`default_nettype wire
